FILE: rtl/awfk_pkg.sv
// Package with the chain tables, sequencing tables and shared constants of the wrist kinematics.
package awfk_pkg;

   localparam int NUM_LINKS  = 10;
   localparam int ROM_LINKS  = 10;
   localparam int LINKS_USED = (NUM_LINKS < ROM_LINKS) ? NUM_LINKS : ROM_LINKS;
   localparam int LINK_W     = 4;

   localparam int ANG_W  = 16;
   localparam int VAL_W  = 32;   // quaternion, matrix and CORDIC values in 2^-28
   localparam int POS_W  = 40;   // running position in 2^-28 m
   localparam int ACC_W  = 68;
   localparam int PX_W   = 24;
   localparam int QO_W   = 18;

   localparam logic signed [VAL_W-1:0] ONE_Q     = 32'sd268435456;
   localparam logic signed [VAL_W-1:0] CORDIC_K  = 32'sd163008219;
   localparam logic signed [VAL_W-1:0] PI_Q      = 32'sd52707179;
   localparam logic signed [VAL_W-1:0] HALF_PI_Q = 32'sd26353589;

   typedef struct packed {
      logic [1:0] ia;
      logic [1:0] ib;
      logic       neg;
   } term_type;

   function automatic logic signed [VAL_W-1:0] atan_val(input logic [3:0] i);
      case (i)
         4'd0:    atan_val = 32'sd13176795;
         4'd1:    atan_val = 32'sd7778716;
         4'd2:    atan_val = 32'sd4110060;
         4'd3:    atan_val = 32'sd2086331;
         4'd4:    atan_val = 32'sd1047214;
         4'd5:    atan_val = 32'sd524117;
         4'd6:    atan_val = 32'sd262123;
         4'd7:    atan_val = 32'sd131069;
         4'd8:    atan_val = 32'sd65536;
         4'd9:    atan_val = 32'sd32768;
         4'd10:   atan_val = 32'sd16384;
         4'd11:   atan_val = 32'sd8192;
         4'd12:   atan_val = 32'sd4096;
         4'd13:   atan_val = 32'sd2048;
         4'd14:   atan_val = 32'sd1024;
         default: atan_val = 32'sd512;
      endcase
   endfunction

   // Joint axis of each link: 0 is x, 1 is y, 2 is z.
   function automatic logic [1:0] link_axis(input logic [LINK_W-1:0] k);
      case (k)
         4'd0:    link_axis = 2'd2;
         4'd1:    link_axis = 2'd0;
         4'd2:    link_axis = 2'd1;
         4'd3:    link_axis = 2'd1;
         4'd4:    link_axis = 2'd0;
         4'd5:    link_axis = 2'd2;
         4'd6:    link_axis = 2'd1;
         4'd7:    link_axis = 2'd0;
         4'd8:    link_axis = 2'd1;
         default: link_axis = 2'd2;
      endcase
   endfunction

   // Link origin offset; the left arm mirrors y.
   function automatic logic signed [VAL_W-1:0] off_val(input logic left,
         input logic [LINK_W-1:0] k, input logic [1:0] c);
      logic signed [VAL_W-1:0] v;
      v = '0;
      case (k)
         4'd1:    v = (c == 2'd0) ? -32'sd1063944 : ((c == 2'd2) ? 32'sd9395241 : 32'sd0);
         4'd2:    v = (c == 2'd2) ? 32'sd5100274 : 32'sd0;
         4'd3: begin
            if (c == 2'd0) v = 32'sd1062011;
            else if (c == 2'd1) v = left ? 32'sd26902601 : -32'sd26899917;
            else if (c == 2'd2) v = 32'sd63828583;
         end
         4'd4: begin
            if (c == 2'd1) v = left ? 32'sd10200547 : -32'sd10200547;
            else if (c == 2'd2) v = -32'sd3712731;
         end
         4'd5: begin
            if (c == 2'd1) v = left ? 32'sd1675037 : -32'sd1675037;
            else if (c == 2'd2) v = -32'sd27702539;
         end
         4'd6:    v = (c == 2'd0) ? 32'sd4236717 : ((c == 2'd2) ? -32'sd21613886 : 32'sd0);
         4'd7: begin
            if (c == 2'd0) v = 32'sd26843546;
            else if (c == 2'd1) v = left ? 32'sd506782 : -32'sd506782;
            else if (c == 2'd2) v = -32'sd2684355;
         end
         4'd8:    v = (c == 2'd0) ? 32'sd10200547 : 32'sd0;
         4'd9:    v = (c == 2'd0) ? 32'sd12348031 : 32'sd0;
         default: v = '0;
      endcase
      off_val = v;
   endfunction

   function automatic logic signed [VAL_W-1:0] tool_val(input logic left, input logic [1:0] c);
      if (c == 2'd0) tool_val = 32'sd48318382;
      else if (c == 2'd1) tool_val = left ? -32'sd6710886 : 32'sd6710886;
      else tool_val = '0;
   endfunction

   // Fixed origin rotation of a link, w first.
   function automatic logic signed [VAL_W-1:0] org_val(input logic left,
         input logic [LINK_W-1:0] k, input logic [1:0] c);
      logic signed [VAL_W-1:0] v;
      v = (c == 2'd0) ? ONE_Q : 32'sd0;
      if (k == 4'd3) begin
         case (c)
            2'd0:    v = 32'sd265821988;
            2'd1:    v = left ? 32'sd37366614 : -32'sd37366614;
            2'd2:    v = 32'sd3724;
            default: v = left ? -32'sd26491 : 32'sd26491;
         endcase
      end else if (k == 4'd4) begin
         case (c)
            2'd0:    v = 32'sd265823111;
            2'd1:    v = left ? -32'sd37358639 : 32'sd37358639;
            default: v = '0;
         endcase
      end
      org_val = v;
   endfunction

   // Sign of term t of output o in a quaternion product; operand b index is o xor t.
   function automatic logic qmul_neg(input logic [1:0] o, input logic [1:0] t);
      case (o)
         2'd0:    qmul_neg = (t != 2'd0);
         2'd1:    qmul_neg = (t == 2'd3);
         2'd2:    qmul_neg = (t == 2'd1);
         default: qmul_neg = (t == 2'd2);
      endcase
   endfunction

   // Two products of each rotation matrix entry, with w x y z as 0 1 2 3.
   function automatic term_type mat_term(input logic [3:0] e, input logic t);
      term_type r;
      r = '{ia: 2'd0, ib: 2'd0, neg: 1'b0};
      case (e)
         4'd0:    r = t ? '{2'd3, 2'd3, 1'b0} : '{2'd2, 2'd2, 1'b0};
         4'd1:    r = t ? '{2'd0, 2'd3, 1'b1} : '{2'd1, 2'd2, 1'b0};
         4'd2:    r = t ? '{2'd0, 2'd2, 1'b0} : '{2'd1, 2'd3, 1'b0};
         4'd3:    r = t ? '{2'd0, 2'd3, 1'b0} : '{2'd1, 2'd2, 1'b0};
         4'd4:    r = t ? '{2'd3, 2'd3, 1'b0} : '{2'd1, 2'd1, 1'b0};
         4'd5:    r = t ? '{2'd0, 2'd1, 1'b1} : '{2'd2, 2'd3, 1'b0};
         4'd6:    r = t ? '{2'd0, 2'd2, 1'b1} : '{2'd1, 2'd3, 1'b0};
         4'd7:    r = t ? '{2'd0, 2'd1, 1'b0} : '{2'd2, 2'd3, 1'b0};
         4'd8:    r = t ? '{2'd2, 2'd2, 1'b0} : '{2'd1, 2'd1, 1'b0};
         default: r = '{ia: 2'd0, ib: 2'd0, neg: 1'b0};
      endcase
      mat_term = r;
   endfunction

endpackage

FILE: rtl/arm_wrist_forward_kinematics.sv
// Forward kinematics of a ten-link arm chain on one shared multiplier and a small sequencer.
//
// Usage: one item on the req_ channel carries ten joint angles (2^-12 rad) in
// req_tdata and the arm select in req_tuser (1 = left). One item on the rsp_
// channel returns the key-frame position (2^-20 m) and the orientation
// quaternion (2^-16, w first), rounded; the position saturates to its field range and
// each quaternion part to plus or minus one. Each link costs a matrix build, an
// offset rotation, two quaternion products and a 16-step CORDIC; the tool offset
// adds one more matrix and rotation. Every product goes through the single 32 by
// 32 multiplier. req_tready is high only while the sequencer is idle, so one
// item is in work at a time. The finished result waits in an output register;
// if the receiver stalls, the sequencer holds its last state until that register
// is free, and then becomes ready again. Reset (synchronous, active high) returns
// the sequencer to idle and drops rsp_tvalid.
module arm_wrist_forward_kinematics
   import awfk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // angle_waist_yaw, angle_waist_roll, angle_waist_pitch, angle_shoulder_pitch,
   // angle_shoulder_roll, angle_shoulder_yaw, angle_elbow, angle_wrist_roll,
   // angle_wrist_pitch, angle_wrist_yaw, 16 bits each from the lowest bit up
   input  logic [159:0] req_tdata,
   // is_left
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_x, pos_y, pos_z (24 bits each), quat_w, quat_x, quat_y, quat_z (18 bits each)
   output logic [143:0] rsp_tdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MAT  = 3'd1;
   localparam logic [2:0] ST_ROT  = 3'd2;
   localparam logic [2:0] ST_QORG = 3'd3;
   localparam logic [2:0] ST_CORD = 3'd4;
   localparam logic [2:0] ST_QJNT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [LINK_W-1:0]       link_ff, link_in;
   logic [3:0]              el_ff, el_in;
   logic [2:0]              tm_ff, tm_in;
   logic                    fin_ff, fin_in;
   logic                    side_ff, side_in;
   logic [ANG_W-1:0]        ang_ff [ROM_LINKS], ang_in [ROM_LINKS];
   logic signed [VAL_W-1:0] q_ff [4], q_in [4];
   logic signed [VAL_W-1:0] o_ff [3], o_in [3];
   logic signed [VAL_W-1:0] m_ff [9], m_in [9];
   logic signed [POS_W-1:0] p_ff [3], p_in [3];
   logic signed [VAL_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic                    cneg_ff, cneg_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [143:0]            rsp_tdata_ff, rsp_tdata_in;

   // Shared multiplier operands.
   logic signed [VAL_W-1:0] op_a, op_b, jb_val, cos_val, sin_val;
   logic                    op_neg, mac_en;
   logic signed [63:0]      prod;
   logic signed [ACC_W-1:0] sprod, acc_base, mat_raw, acc_rnd;
   logic [1:0]              qb_idx;
   logic [3:0]              m_idx;
   term_type                mt;
   logic signed [VAL_W-1:0] h_val, h_fold;
   logic                    h_neg;
   logic signed [VAL_W-1:0] cdx, cdy;
   logic signed [31:0]      pos_r [3];
   logic signed [19:0]      quat_r [4];
   logic [PX_W-1:0]         pos_s [3];
   logic [QO_W-1:0]         quat_s [4];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The CORDIC keeps its raw vector; the fold of the angle is applied on read.
   assign cos_val = cneg_ff ? -cx_ff : cx_ff;
   assign sin_val = cneg_ff ? -cy_ff : cy_ff;
   assign qb_idx  = el_ff[1:0] ^ tm_ff[1:0];
   assign mt      = mat_term(el_ff, tm_ff[0]);
   assign m_idx   = (tm_ff == 3'd3) ? 4'd0
                    : ({2'b00, el_ff[1:0]} * 4'd3) + {2'b00, tm_ff[1:0]};

   always_comb begin
      if (qb_idx == 2'd0) jb_val = cos_val;
      else if (qb_idx == 2'(link_axis(link_ff) + 2'd1)) jb_val = sin_val;
      else jb_val = '0;
   end

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_neg = 1'b0;
      mac_en = 1'b0;
      case (state_ff)
         ST_MAT: begin
            op_a   = q_ff[mt.ia];
            op_b   = q_ff[mt.ib];
            op_neg = mt.neg;
            mac_en = (tm_ff < 3'd2);
         end
         ST_ROT: begin
            op_a   = m_ff[m_idx];
            op_b   = fin_ff ? tool_val(side_ff, tm_ff[1:0])
                            : off_val(side_ff, link_ff, tm_ff[1:0]);
            mac_en = (tm_ff < 3'd3);
         end
         ST_QORG: begin
            op_a   = q_ff[tm_ff[1:0]];
            op_b   = org_val(side_ff, link_ff, qb_idx);
            op_neg = qmul_neg(el_ff[1:0], tm_ff[1:0]);
            mac_en = (tm_ff < 3'd4);
         end
         ST_QJNT: begin
            op_a   = q_ff[tm_ff[1:0]];
            op_b   = jb_val;
            op_neg = qmul_neg(el_ff[1:0], tm_ff[1:0]);
            mac_en = (tm_ff < 3'd4);
         end
         default: begin
            op_a   = '0;
         end
      endcase
   end

   assign prod     = op_a * op_b;
   assign sprod    = op_neg ? -ACC_W'(prod) : ACC_W'(prod);
   assign acc_base = (tm_ff == 3'd0) ? '0 : acc_ff;

   // Matrix entry before rounding: diagonals are one minus twice the sum.
   assign mat_raw = ((el_ff == 4'd0) || (el_ff == 4'd4) || (el_ff == 4'd8))
                    ? ((ACC_W'(1) <<< 56) - (acc_ff <<< 1)) : (acc_ff <<< 1);
   assign acc_rnd = ((state_ff == ST_MAT) ? mat_raw : acc_ff) + (ACC_W'(1) <<< 27);

   // Half joint angle in 2^-24 rad, folded into the CORDIC range.
   assign h_val = {{5{ang_ff[link_ff][ANG_W-1]}}, ang_ff[link_ff], 11'b0};
   always_comb begin
      h_neg  = 1'b0;
      h_fold = h_val;
      if (h_val > HALF_PI_Q) begin
         h_fold = h_val - PI_Q;
         h_neg  = 1'b1;
      end else if (h_val < -HALF_PI_Q) begin
         h_fold = h_val + PI_Q;
         h_neg  = 1'b1;
      end
   end

   assign cdx = cy_ff >>> el_ff;
   assign cdy = cx_ff >>> el_ff;

   // Output rounding and saturation.
   always_comb begin
      logic signed [POS_W-1:0] pt;
      logic signed [VAL_W-1:0] qt;
      for (int k = 0; k < 3; k++) begin
         pt       = p_ff[k] + POS_W'(128);
         pos_r[k] = pt[39:8];
         if (pos_r[k] > 32'sd8388607) pos_s[k] = 24'h7FFFFF;
         else if (pos_r[k] < -32'sd8388608) pos_s[k] = 24'h800000;
         else pos_s[k] = pos_r[k][PX_W-1:0];
      end
      for (int k = 0; k < 4; k++) begin
         qt        = q_ff[k] + VAL_W'(2048);
         quat_r[k] = qt[31:12];
         if (quat_r[k] > 20'sd65536) quat_s[k] = 18'h10000;
         else if (quat_r[k] < -20'sd65536) quat_s[k] = 18'h30000;
         else quat_s[k] = quat_r[k][QO_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      link_in       = link_ff;
      el_in         = el_ff;
      tm_in         = tm_ff;
      fin_in        = fin_ff;
      side_in       = side_ff;
      ang_in        = ang_ff;
      q_in          = q_ff;
      o_in          = o_ff;
      m_in          = m_ff;
      p_in          = p_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      cneg_in       = cneg_ff;
      acc_in        = acc_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      if (mac_en) acc_in = acc_base + sprod;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               for (int k = 0; k < ROM_LINKS; k++) ang_in[k] = req_tdata[k*ANG_W +: ANG_W];
               side_in  = req_tuser;
               q_in[0]  = ONE_Q;
               q_in[1]  = '0;
               q_in[2]  = '0;
               q_in[3]  = '0;
               for (int k = 0; k < 3; k++) p_in[k] = '0;
               link_in  = '0;
               fin_in   = 1'b0;
               el_in    = '0;
               tm_in    = '0;
               state_in = ST_MAT;
            end
         end
         ST_MAT: begin
            if (tm_ff == 3'd2) begin
               m_in[el_ff] = acc_rnd[59:28];
               tm_in       = '0;
               if (el_ff == 4'd8) begin
                  el_in    = '0;
                  state_in = ST_ROT;
               end else begin
                  el_in = el_ff + 4'd1;
               end
            end else begin
               tm_in = tm_ff + 3'd1;
            end
         end
         ST_ROT: begin
            if (tm_ff == 3'd3) begin
               p_in[el_ff[1:0]] = p_ff[el_ff[1:0]] + acc_rnd[67:28];
               tm_in            = '0;
               if (el_ff == 4'd2) begin
                  el_in    = '0;
                  state_in = fin_ff ? ST_DONE : ST_QORG;
               end else begin
                  el_in = el_ff + 4'd1;
               end
            end else begin
               tm_in = tm_ff + 3'd1;
            end
         end
         ST_QORG, ST_QJNT: begin
            if (tm_ff == 3'd4) begin
               tm_in = '0;
               if (el_ff == 4'd3) begin
                  q_in[0] = o_ff[0];
                  q_in[1] = o_ff[1];
                  q_in[2] = o_ff[2];
                  q_in[3] = acc_rnd[59:28];
                  el_in   = '0;
                  if (state_ff == ST_QORG) begin
                     cx_in    = CORDIC_K;
                     cy_in    = '0;
                     cz_in    = h_fold;
                     cneg_in  = h_neg;
                     state_in = ST_CORD;
                  end else begin
                     state_in = ST_MAT;
                     if (link_ff == LINK_W'(LINKS_USED - 1)) fin_in = 1'b1;
                     else link_in = link_ff + 1'b1;
                  end
               end else begin
                  o_in[el_ff[1:0]] = acc_rnd[59:28];
                  el_in            = el_ff + 4'd1;
               end
            end else begin
               tm_in = tm_ff + 3'd1;
            end
         end
         ST_CORD: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - cdx;
               cy_in = cy_ff + cdy;
               cz_in = cz_ff - atan_val(el_ff);
            end else begin
               cx_in = cx_ff + cdx;
               cy_in = cy_ff - cdy;
               cz_in = cz_ff + atan_val(el_ff);
            end
            el_in = el_ff + 4'd1;
            if (el_ff == 4'd15) begin
               el_in    = '0;
               tm_in    = '0;
               state_in = ST_QJNT;
            end
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = {quat_s[3], quat_s[2], quat_s[1], quat_s[0],
                                pos_s[2], pos_s[1], pos_s[0]};
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      link_ff      <= link_in;
      el_ff        <= el_in;
      tm_ff        <= tm_in;
      fin_ff       <= fin_in;
      side_ff      <= side_in;
      ang_ff       <= ang_in;
      q_ff         <= q_in;
      o_ff         <= o_in;
      m_ff         <= m_in;
      p_ff         <= p_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      cneg_ff      <= cneg_in;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the ten-link arm forward kinematics block.
module testbench;
   import awfk_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [159:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;

   // One pose request: the arm select and ten joint angles in chain order.
   typedef struct packed {
      logic         left;
      logic [159:0] angles;
   } pose_req_type;

   // One pose: position in 2^-20 m and orientation quaternion in 2^-16, w first.
   typedef struct {
      logic signed [PX_W-1:0] pos [3];
      logic signed [QO_W-1:0] quat [4];
   } pose_type;

   pose_req_type pending_reqs[$];
   pose_type     expected_poses[$];
   int           fail_count = 0;
   bit           stim_done = 1'b0;
   bit           idle_free = 1'b0;
   bit           req_taken = 1'b0;
   int           hold_cycles = 0;

   arm_wrist_forward_kinematics u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   // Chain tables, written independently of the package functions.
   localparam int AXIS [10] = '{2, 0, 1, 1, 0, 2, 1, 0, 1, 2};
   localparam longint ATAN [16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
      262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
   localparam longint ONE = 268435456;

   // Floor shift right and round half up.
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void link_offset(bit left, int k, output longint v [3]);
      longint sy;
      sy = left ? 1 : -1;
      v = '{0, 0, 0};
      case (k)
         1: v = '{-1063944, 0, 9395241};
         2: v = '{0, 0, 5100274};
         3: v = '{1062011, left ? 26902601 : -26899917, 63828583};
         4: v = '{0, sy * 10200547, -3712731};
         5: v = '{0, sy * 1675037, -27702539};
         6: v = '{4236717, 0, -21613886};
         7: v = '{26843546, sy * 506782, -2684355};
         8: v = '{10200547, 0, 0};
         9: v = '{12348031, 0, 0};
         default: ;
      endcase
   endfunction

   function automatic void link_origin(bit left, int k, output longint q [4]);
      longint sy;
      sy = left ? 1 : -1;
      q = '{ONE, 0, 0, 0};
      if (k == 3) q = '{265821988, sy * 37366614, 3724, -sy * 26491};
      if (k == 4) q = '{265823111, -sy * 37358639, 0, 0};
   endfunction

   // Cosine and sine of half the joint angle, folded into the CORDIC's range.
   function automatic void half_angle_trig(logic signed [15:0] a, output longint c,
         output longint s);
      longint h, x, y, dx, dy;
      bit flip;
      h = longint'(a) * 2048;
      x = 163008219;
      y = 0;
      flip = 1'b0;
      if (h > 26353589) begin
         h -= 52707179;
         flip = 1'b1;
      end else if (h < -26353589) begin
         h += 52707179;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (h >= 0) begin
            x -= dx; y += dy; h -= ATAN[i];
         end else begin
            x += dx; y -= dy; h += ATAN[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic void quat_product(ref longint r [4], input longint b [4]);
      longint o [4];
      o[0] = round_shr(r[0]*b[0] - r[1]*b[1] - r[2]*b[2] - r[3]*b[3], 28);
      o[1] = round_shr(r[0]*b[1] + r[1]*b[0] + r[2]*b[3] - r[3]*b[2], 28);
      o[2] = round_shr(r[0]*b[2] - r[1]*b[3] + r[2]*b[0] + r[3]*b[1], 28);
      o[3] = round_shr(r[0]*b[3] + r[1]*b[2] - r[2]*b[1] + r[3]*b[0], 28);
      r = o;
   endfunction

   // Adds the vector v, rotated by the matrix of quaternion q, to position p.
   function automatic void move_by_rotated(longint q [4], longint v [3], ref longint p [3]);
      longint w, x, y, z, one;
      longint m [3][3];
      w = q[0]; x = q[1]; y = q[2]; z = q[3];
      one = longint'(1) <<< 56;
      m[0][0] = round_shr(one - 2 * (y*y + z*z), 28);
      m[0][1] = round_shr(2 * (x*y - w*z), 28);
      m[0][2] = round_shr(2 * (x*z + w*y), 28);
      m[1][0] = round_shr(2 * (x*y + w*z), 28);
      m[1][1] = round_shr(one - 2 * (x*x + z*z), 28);
      m[1][2] = round_shr(2 * (y*z - w*x), 28);
      m[2][0] = round_shr(2 * (x*z - w*y), 28);
      m[2][1] = round_shr(2 * (y*z + w*x), 28);
      m[2][2] = round_shr(one - 2 * (x*x + y*y), 28);
      for (int k = 0; k < 3; k++)
         p[k] += round_shr(m[k][0]*v[0] + m[k][1]*v[1] + m[k][2]*v[2], 28);
   endfunction

   function automatic pose_type wrist_pose(pose_req_type rq);
      longint p [3], r [4], org [4], jq [4], off [3], tool [3];
      longint c, s;
      pose_type res;
      p = '{0, 0, 0};
      r = '{ONE, 0, 0, 0};
      for (int i = 0; i < LINKS_USED; i++) begin
         link_offset(rq.left, i, off);
         move_by_rotated(r, off, p);
         link_origin(rq.left, i, org);
         quat_product(r, org);
         half_angle_trig(rq.angles[16*i +: 16], c, s);
         jq = '{c, 0, 0, 0};
         jq[1 + AXIS[i]] = s;
         quat_product(r, jq);
      end
      tool = '{48318382, rq.left ? -6710886 : 6710886, 0};
      move_by_rotated(r, tool, p);
      for (int k = 0; k < 3; k++)
         res.pos[k] = PX_W'(clamp(round_shr(p[k], 8), -8388608, 8388607));
      for (int k = 0; k < 4; k++)
         res.quat[k] = QO_W'(clamp(round_shr(r[k], 12), -65536, 65536));
      return res;
   endfunction

   function automatic pose_req_type random_pose_req();
      pose_req_type rq;
      rq.left = 1'($urandom_range(0, 1));
      for (int i = 0; i < 10; i++) begin
         case ($urandom_range(0, 3))
            0: rq.angles[16*i +: 16] = 16'($urandom());
            1: rq.angles[16*i +: 16] = 16'($urandom_range(0, 12868) - 6434); // within +-pi/2
            2: rq.angles[16*i +: 16] = 16'($urandom_range(0, 400) - 200);
            default: rq.angles[16*i +: 16] = 16'($urandom_range(0, 25736) - 12868);
         endcase
      end
      return rq;
   endfunction

   // Directed items, then random ones.
   initial begin
      pose_req_type rq;
      logic [15:0] fixed [8];
      fixed = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                16'd6434, -16'sd6434, 16'd12868};
      for (int side = 0; side < 2; side++)
         for (int v = 0; v < 8; v++) begin
            rq.left = side[0];
            rq.angles = {10{fixed[v]}};
            pending_reqs.push_back(rq);
         end
      // Alternating patterns so each angle bit is seen at both values per joint.
      rq.left = 1'b1; rq.angles = {10{16'hAAAA}}; pending_reqs.push_back(rq);
      rq.left = 1'b0; rq.angles = {10{16'h5555}}; pending_reqs.push_back(rq);
      // Two adjacent joints at a time driven to the half-angle fold boundary.
      for (int i = 0; i < 5; i++) begin
         rq.left = i[0];
         rq.angles = '0;
         rq.angles[16*(2*i) +: 16] = 16'd12868;
         rq.angles[16*(2*i+1) +: 16] = 16'd12869;
         pending_reqs.push_back(rq);
      end
      for (int n = 0; n < 1150; n++) pending_reqs.push_back(random_pose_req());
   end

   // Reset, then the stall schedule: a stretch without idling and one long hold-off.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (pending_reqs.size() < 1100);
      idle_free = 1'b1;
      wait (pending_reqs.size() < 1050);
      idle_free = 1'b0;
      wait (pending_reqs.size() < 900);
      hold_cycles = 6000;
   end

   // Remembers at the rising edge whether the offered item was taken.
   always @(posedge clock) begin
      req_taken <= !reset && req_tvalid && req_tready;
   end

   // Sender: offers queued items and changes inputs on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // Item is held until accepted.
      end else begin
         if (req_taken) void'(pending_reqs.pop_front());
         if (pending_reqs.size() > 0 && (idle_free || $urandom_range(0, 99) >= 30)) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs[0].angles;
            req_tuser <= pending_reqs[0].left;
         end else begin
            req_tvalid <= 1'b0;
         end
         if (pending_reqs.size() == 0) stim_done <= 1'b1;
      end
   end

   // Receiver readiness, including the counted long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= idle_free || $urandom_range(0, 99) >= 30;
      end
   end

   // Predicts on acceptance and checks each result against the oldest prediction.
   always @(posedge clock) begin
      pose_type got, want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_poses.push_back(wrist_pose('{req_tuser, req_tdata}));
         if (rsp_tvalid && rsp_tready) begin
            for (int k = 0; k < 3; k++) got.pos[k] = rsp_tdata[24*k +: 24];
            for (int k = 0; k < 4; k++) got.quat[k] = rsp_tdata[72 + 18*k +: 18];
            if (expected_poses.size() == 0) begin
               $error("unexpected result item");
               fail_count++;
            end else begin
               want = expected_poses.pop_front();
               for (int k = 0; k < 3; k++)
                  if (got.pos[k] !== want.pos[k]) begin
                     $error("pos_%s expected %0d got %0d", k == 0 ? "x" : (k == 1 ? "y" : "z"),
                            want.pos[k], got.pos[k]);
                     fail_count++;
                  end
               for (int k = 0; k < 4; k++)
                  if (got.quat[k] !== want.quat[k]) begin
                     $error("quat_%s expected %0d got %0d",
                            k == 0 ? "w" : (k == 1 ? "x" : (k == 2 ? "y" : "z")),
                            want.quat[k], got.quat[k]);
                     fail_count++;
                  end
            end
         end
      end
   end

   // End of run once every prediction has been met.
   initial begin
      wait (stim_done);
      wait (expected_poses.size() == 0);
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && expected_poses.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

   // Generous limit: about 1200 items, with stalls.
   initial begin
      #120000000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule
